/* hw/rtl/lss_pkg.sv */
// Shared constants for the latency/size statistics block.
// No dependencies; imported by lss_div, lss_mul and the top level.
package lss_pkg;

  localparam int unsigned TIME_W  = 63;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned STAT_W  = 64;
  localparam int unsigned STEP_W  = 6;   // counts the 64 serial steps

  localparam int unsigned IN_DATA_W  = 160;  // 158 bits of fields, padded to bytes
  localparam int unsigned OUT_DATA_W = 448;

  localparam logic [STAT_W-1:0] U64_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [STAT_W-1:0] LAT_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SIZE_W-1:0] SIZE_ONES   = 32'hFFFF_FFFF;

  localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;

  // status classes
  localparam logic [CLS_W-1:0] CLS_OK        = 2'd0;
  localparam logic [CLS_W-1:0] CLS_NOT_FOUND = 2'd1;
  localparam logic [CLS_W-1:0] CLS_TIMEOUT   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_OTHER     = 2'd3;

endpackage

/* hw/rtl/lss_div.sv */
// Bit-serial restoring divider with round-to-nearest: (x + d/2) / d, unsigned 64-bit.
// A pre-add step, then one quotient bit per cycle. Uses lss_pkg.
module lss_div
  import lss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STAT_W-1:0] dividend,
  input  logic [STAT_W-1:0] divisor,
  output logic              done,
  output logic [STAT_W-1:0] quotient
);

  logic              busy_r;
  logic              pre_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [STAT_W-1:0] q_r;
  logic [STAT_W-1:0] d_r;
  logic [STAT_W:0]   rem_r;

  logic [STAT_W:0]   rem_sh;
  logic [STAT_W:0]   rem_nxt;
  logic [STAT_W-1:0] q_nxt;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_r[STAT_W-1:0], q_r[STAT_W-1]};
    qbit    = (rem_sh >= {1'b0, d_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
    q_nxt   = {q_r[STAT_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pre_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pre_r  <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (pre_r) begin
          pre_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // dividend shifts out of q_r from the top while quotient bits enter below;
  // a zero divisor yields all ones
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (pre_r) begin
        q_r <= q_r + {1'b0, d_r[STAT_W-1:1]};
      end else begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* hw/rtl/lss_mul.sv */
// Bit-serial shift-add multiplier, low 64 bits of a 64x64 product.
// One multiplier bit per cycle. Uses lss_pkg.
module lss_mul
  import lss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STAT_W-1:0] op_a,
  input  logic [STAT_W-1:0] op_b,
  output logic              done,
  output logic [STAT_W-1:0] product
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [STAT_W-1:0] a_r;
  logic [STAT_W-1:0] b_r;
  logic [STAT_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
      p_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= {a_r[STAT_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[STAT_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

/* hw/rtl/latency_size_statistics_unit.sv */
// Latency/size statistics over completed requests, with squared deviations.
// Depends on lss_pkg, lss_div (two instances) and lss_mul.
//
// Usage:
//  - in_* channel takes one completed request: in_tdata holds start time,
//    end time and transfer size; in_tuser holds the status class.
//  - out_* channel returns one result per request: out_tuser the accepted
//    flag, out_tdata all running statistics after the update.
//  - One request at a time. A counted request from the second sample on
//    passes from accept to out_tvalid through capture (S_LAT) and update
//    (S_UPD), the two round-to-nearest dividers side by side (S_DIV), then
//    the serial multiplier (S_MUL) and the output load (S_OUT). The first
//    sample skips dividers and multiplier; an ignored request (other-error
//    class) skips the update too.
//  - in_tready rises the cycle after a result is loaded.
//  - The output register holds a result until out_tready; the next request
//    can be accepted and processed meanwhile, and waits in the final state
//    only if the previous result is still not taken.
//  - Synchronous active-low reset clears all statistics to their empty
//    values (minimums to the largest value, the rest to zero) and drops
//    out_tvalid.
module latency_size_statistics_unit
  import lss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [62:0] start_time, [125:63] end_time, [157:126] xfer_size, [159:158] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] status_class
  input  logic [CLS_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] request_count, [127:64] size_total, [159:128] size_smallest,
  // [191:160] size_largest, [255:192] latency_total,
  // [319:256] latency_smallest, [383:320] latency_largest,
  // [447:384] latency_sq_dev
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] accepted
  output logic                  out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LAT  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        st_r;

  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] end_r;
  logic [SIZE_W-1:0] size_r;
  logic [CLS_W-1:0]  cls_r;
  logic [STAT_W-1:0] lat_r;
  logic              acc_r;

  logic [STAT_W-1:0] count_r;
  logic [STAT_W-1:0] size_acc_r;
  logic [SIZE_W-1:0] size_lo_r;
  logic [SIZE_W-1:0] size_hi_r;
  logic [STAT_W-1:0] lat_sum_r;
  logic [STAT_W-1:0] lat_min_r;
  logic [STAT_W-1:0] lat_max_r;
  logic [STAT_W-1:0] sq_sum_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  logic              div_start;
  logic              div_old_done;
  logic              div_new_done;
  logic [STAT_W-1:0] avg_old;
  logic [STAT_W-1:0] avg_new;
  logic              mul_start;
  logic              mul_done;
  logic [STAT_W-1:0] mul_a;
  logic [STAT_W-1:0] mul_b;
  logic [STAT_W-1:0] prod;
  logic              out_load;

  assign in_tready = (st_r == S_IDLE);

  // old mean uses the sum before this sample over the old count; the new one
  // the updated sum over the updated count
  assign div_start = (st_r == S_UPD) && (count_r != '0);
  assign mul_start = (st_r == S_DIV) && div_old_done && div_new_done;
  assign mul_a     = lat_r - avg_old;
  assign mul_b     = lat_r - avg_new;
  assign out_load  = (st_r == S_OUT) && (!out_tvalid_r || out_tready);

  lss_div u_div_old (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lat_sum_r),
    .divisor  (count_r),
    .done     (div_old_done),
    .quotient (avg_old)
  );

  lss_div u_div_new (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lat_sum_r + lat_r),
    .divisor  (count_r + 64'd1),
    .done     (div_new_done),
    .quotient (avg_new)
  );

  lss_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  // request capture and latency
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      start_r <= in_tdata[TIME_W-1:0];
      end_r   <= in_tdata[2*TIME_W-1:TIME_W];
      size_r  <= in_tdata[2*TIME_W+SIZE_W-1:2*TIME_W];
      cls_r   <= in_tuser;
    end
    if (st_r == S_LAT) begin
      lat_r <= {1'b0, end_r} - {1'b0, start_r};
      acc_r <= (cls_r != CLS_OTHER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      count_r      <= '0;
      size_acc_r   <= '0;
      size_lo_r    <= SIZE_ONES;
      size_hi_r    <= '0;
      lat_sum_r    <= '0;
      lat_min_r    <= LAT_POS_MAX;
      lat_max_r    <= '0;
      sq_sum_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            st_r <= S_LAT;
          end
        end
        S_LAT: begin
          st_r <= (cls_r == CLS_OTHER) ? S_OUT : S_UPD;
        end
        S_UPD: begin
          count_r    <= count_r + 64'd1;
          size_acc_r <= size_acc_r + {32'd0, size_r};
          lat_sum_r  <= lat_sum_r + lat_r;
          if (size_r < size_lo_r) begin
            size_lo_r <= size_r;
          end
          if (size_r > size_hi_r) begin
            size_hi_r <= size_r;
          end
          if ($signed(lat_r) < $signed(lat_min_r)) begin
            lat_min_r <= lat_r;
          end
          if ($signed(lat_max_r) < $signed(lat_r)) begin
            lat_max_r <= lat_r;
          end
          st_r <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (mul_start) begin
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            sq_sum_r <= sq_sum_r + prod;
            st_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tuser_r <= acc_r;
      out_tdata_r <= {sq_sum_r, lat_max_r, lat_min_r, lat_sum_r,
                      size_hi_r, size_lo_r, size_acc_r, count_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
